// File: hw/rtl/tars_pkg.sv
// Time series store package: sizes, command and status codes, transfer
// structs and the control structs between the sequencer and the directory.
// No dependencies.
package tars_pkg;

    localparam int MAX_SERIES  = 16;
    localparam int MAX_ENTRIES = 256;

    localparam int SER_W   = $clog2(MAX_SERIES);
    localparam int USE_W   = $clog2(MAX_SERIES + 1);
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W  = SER_W + IDX_W;
    localparam int DEPTH   = MAX_SERIES * MAX_ENTRIES;
    localparam int TIME_W  = 64;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = TIME_W + VAL_W;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_ENDS   = 2'd2,
        CMD_RANGE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_EMPTY  = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t                command;
        logic [SER_W-1:0]    series;
        logic [TIME_W-1:0]   stamp;
        logic [VAL_W-1:0]    sample_value;
        logic                which_end;
        logic [TIME_W-1:0]   range_start;
        logic [TIME_W-1:0]   range_end;
    } cmd_item_t;

    typedef struct packed {
        status_t             status;
        logic [SER_W-1:0]    created_series;
        logic [TIME_W-1:0]   time_out;
        logic [IDX_W-1:0]    first_index;
        logic [CNT_W-1:0]    match_count;
    } rsp_item_t;

    typedef struct packed {
        logic                create;
        logic                append;
        logic [SER_W-1:0]    series;
    } dir_req_t;

    typedef struct packed {
        logic [USE_W-1:0]    in_use;
        logic [CNT_W-1:0]    fill;
    } dir_info_t;

endpackage

// File: hw/rtl/tars_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module tars_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/tars_dir.sv
// Series directory: fill count per series and number of series created.
// Depends on tars_pkg.
module tars_dir
    import tars_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dir_req_t  req,
    output dir_info_t info
);

    logic [CNT_W-1:0] fill_reg [MAX_SERIES];
    logic [USE_W-1:0] in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERIES; i++)
            begin
                fill_reg[i] <= '0;
            end
            in_use_reg <= '0;
        end
        else
        begin
            if (req.create)
            begin
                fill_reg[in_use_reg[SER_W-1:0]] <= '0;
                in_use_reg <= in_use_reg + USE_W'(1);
            end
            if (req.append)
            begin
                fill_reg[req.series] <= fill_reg[req.series] + CNT_W'(1);
            end
        end
    end

    assign info.in_use = in_use_reg;
    assign info.fill   = fill_reg[req.series];

endmodule

// File: hw/rtl/tars_ctrl.sv
// Command sequencer: decodes one command, drives the entry RAM and runs the
// range scan through one shared 64-bit less-than compare.
// Depends on tars_pkg.
module tars_ctrl
    import tars_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  cmd_item_t          cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output rsp_item_t          res,
    output dir_req_t           dir_req,
    input  dir_info_t          dir_info,
    output logic               ram_we,
    output logic [ADDR_W-1:0]  ram_addr,
    output logic [ENTRY_W-1:0] ram_wdata,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENDS,
        S_LAST,
        S_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg;
    cmd_item_t         item_reg;
    rsp_item_t         res_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  lo_reg;
    logic              phase_reg;

    logic [SER_W-1:0]  s;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  last_idx;
    logic [CNT_W-1:0]  idx_inc;
    logic              known;
    logic              table_full;
    logic              series_full;
    logic [TIME_W-1:0] ram_time;
    logic [TIME_W-1:0] bound;
    logic              less;
    logic              scan_end;
    logic [CNT_W-1:0]  hi_val;
    logic [CNT_W-1:0]  lo_val;
    logic [CNT_W-1:0]  span;

    assign s           = item_reg.series;
    assign n           = dir_info.fill;
    assign last_idx    = n - CNT_W'(1);
    assign idx_inc     = idx_reg + CNT_W'(1);
    assign known       = USE_W'(s) < dir_info.in_use;
    assign table_full  = dir_info.in_use == USE_W'(MAX_SERIES);
    assign series_full = n == CNT_W'(MAX_ENTRIES);

    // shared compare unit; value half of the entry is stored only
    assign ram_time = ram_rdata[TIME_W-1:0];
    assign bound    = phase_reg ? item_reg.range_end : item_reg.range_start;
    assign less     = ram_time < bound;

    assign scan_end = less ? (idx_inc == n) : phase_reg;
    assign hi_val   = less ? n : idx_reg;
    assign lo_val   = phase_reg ? lo_reg : n;
    assign span     = hi_val - lo_val;

    assign cmd_ready = state_reg == S_IDLE;
    assign res_valid = state_reg == S_DONE;
    assign res       = res_reg;

    always_comb
    begin
        ram_we         = 1'b0;
        ram_addr       = {s, IDX_W'(0)};
        ram_wdata      = {item_reg.sample_value, item_reg.stamp};
        dir_req.create = 1'b0;
        dir_req.append = 1'b0;
        dir_req.series = s;
        case (state_reg)
            S_EXEC:
            begin
                case (item_reg.command)
                    CMD_CREATE:
                    begin
                        dir_req.create = !table_full;
                    end
                    CMD_APPEND:
                    begin
                        ram_we         = known && !series_full;
                        dir_req.append = known && !series_full;
                        ram_addr       = {s, n[IDX_W-1:0]};
                    end
                    CMD_ENDS:
                    begin
                        if (item_reg.which_end)
                        begin
                            ram_addr = {s, last_idx[IDX_W-1:0]};
                        end
                    end
                    CMD_RANGE:
                    begin
                        ram_addr = {s, last_idx[IDX_W-1:0]};
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
            S_SCAN:
            begin
                ram_addr = less ? {s, idx_inc[IDX_W-1:0]} : {s, idx_reg[IDX_W-1:0]};
            end
            default:
            begin
                ram_addr = {s, IDX_W'(0)};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            item_reg  <= '0;
            res_reg   <= '0;
            idx_reg   <= '0;
            lo_reg    <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        item_reg  <= cmd;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    res_reg   <= '0;
                    phase_reg <= 1'b0;
                    idx_reg   <= '0;
                    state_reg <= S_DONE;
                    if (item_reg.command == CMD_CREATE)
                    begin
                        if (table_full)
                        begin
                            res_reg.status <= ST_REJECT;
                        end
                        else
                        begin
                            res_reg.created_series <= dir_info.in_use[SER_W-1:0];
                        end
                    end
                    else if (!known)
                    begin
                        res_reg.status <= ST_REJECT;
                    end
                    else if (item_reg.command == CMD_APPEND)
                    begin
                        if (series_full)
                        begin
                            res_reg.status <= ST_REJECT;
                        end
                    end
                    else if (n == '0)
                    begin
                        res_reg.status <= ST_EMPTY;
                    end
                    else if (item_reg.command == CMD_ENDS)
                    begin
                        state_reg <= S_ENDS;
                    end
                    else
                    begin
                        state_reg <= S_LAST;
                    end
                end
                S_ENDS:
                begin
                    res_reg.time_out <= ram_time;
                    state_reg        <= S_DONE;
                end
                S_LAST:
                begin
                    // range start beyond the last sample
                    if (less)
                    begin
                        res_reg.status <= ST_EMPTY;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_end)
                    begin
                        state_reg <= S_DONE;
                        if (hi_val > lo_val)
                        begin
                            res_reg.first_index <= lo_val[IDX_W-1:0];
                            res_reg.match_count <= span;
                        end
                        else
                        begin
                            res_reg.status <= ST_EMPTY;
                        end
                    end
                    else if (less)
                    begin
                        idx_reg <= idx_inc;
                    end
                    else
                    begin
                        // start found: same entry is tested again against the end bound
                        lo_reg    <= idx_reg;
                        phase_reg <= 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/timeseries_append_range_store_top.sv
// Time series store: up to MAX_SERIES append-only series of timestamped
// samples, held in one entry RAM of MAX_SERIES * MAX_ENTRIES words. Every
// command transfer yields one response transfer. The block takes one command
// at a time. A range query runs a scan that reads one RAM entry per cycle
// through a single 64-bit compare. The response sits in an output register,
// so the sequencer frees up while a response waits to be taken. No clearing
// pass after reset.
// Depends on tars_pkg, tars_ram, tars_dir, tars_ctrl.
module timeseries_append_range_store_top
    import tars_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    logic               res_valid;
    logic               res_ready;
    rsp_item_t          res;
    dir_req_t           dir_req;
    dir_info_t          dir_info;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic               rsp_valid_reg;
    rsp_item_t          rsp_reg;

    tars_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .dir_req   (dir_req),
        .dir_info  (dir_info),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    tars_dir u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dir_req),
        .info  (dir_info)
    );

    tars_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: hw/rtl/tars_checker.sv
// Port-level checks for the time series store, bound to the top level.
// Depends on tars_pkg and timeseries_append_range_store_top.
module tars_checker
    import tars_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input logic      rsp_valid,
    input logic      rsp_ready,
    input rsp_item_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while previous one in progress");

    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(cmd_ready))
        else $error("response appeared without a command in progress");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_OK |->
            rsp.created_series == '0 && rsp.time_out == '0 &&
            rsp.first_index == '0 && rsp.match_count == '0)
        else $error("failed response carries nonzero fields");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.match_count <= CNT_W'(MAX_ENTRIES))
        else $error("match count beyond series capacity");

endmodule

bind timeseries_append_range_store_top tars_checker u_tars_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

// File: bench/tb_timeseries_append_range_store_top.sv
// Self-checking bench for timeseries_append_range_store_top: a directed table of commands,
// then random traffic with one series flooded to capacity, checked field by field.
// Depends on tars_pkg and the time series store RTL.
`timescale 1ns / 1ps

module tb_timeseries_append_range_store_top;

    import tars_pkg::*;

    localparam int                N_RANDOM     = 700;
    localparam int                FLOOD_AT     = 150;
    localparam int                FLOOD_LEN    = 320;
    localparam int                FLOOD_SERIES = 1;
    localparam int                TAIL         = 100;
    localparam int                DRAIN        = 300;
    localparam int                LIMIT        = 1000000;
    localparam logic [TIME_W-1:0] TOP_STAMP    = '1;

    typedef struct {
        cmd_item_t item;
        bit        typed;
        rsp_item_t want;
    } plan_row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    logic [TIME_W-1:0] ser_times [MAX_SERIES][MAX_ENTRIES];
    int                ser_fill [MAX_SERIES];
    int                ser_made    = 0;
    rsp_item_t         replies_due [$];
    plan_row_t         plan_rows [$];
    int                feed_pct    = 0;
    int                sink_pct    = 0;
    int                cycle_count = 0;
    bit                failed      = 1'b0;

    timeseries_append_range_store_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Apply one command to the local copy of the store and return its response.
    function automatic rsp_item_t series_reply(cmd_item_t c);
        rsp_item_t r;
        int        s;
        int        n;
        int        i;
        int        lo;
        int        hi;
        r = '0;
        r.status = ST_OK;
        s = int'(c.series);
        if (c.command == CMD_CREATE)
        begin
            if (ser_made >= MAX_SERIES)
                r.status = ST_REJECT;
            else
            begin
                r.created_series = SER_W'(ser_made);
                ser_fill[ser_made] = 0;
                ser_made++;
            end
        end
        else if (s >= ser_made)
            r.status = ST_REJECT;
        else
        begin
            n = ser_fill[s];
            if (c.command == CMD_APPEND)
            begin
                if (n >= MAX_ENTRIES)
                    r.status = ST_REJECT;
                else
                begin
                    ser_times[s][n] = c.stamp;
                    ser_fill[s] = n + 1;
                end
            end
            else if (n == 0)
                r.status = ST_EMPTY;
            else if (c.command == CMD_ENDS)
                r.time_out = c.which_end ? ser_times[s][n - 1] : ser_times[s][0];
            else
            begin
                i = 0;
                lo = 0;
                hi = 0;
                if (c.range_start <= ser_times[s][n - 1])
                begin
                    while (i < n && ser_times[s][i] < c.range_start) i++;
                    lo = i;
                    while (i < n && ser_times[s][i] < c.range_end) i++;
                    hi = i;
                end
                if (hi > lo)
                begin
                    r.first_index = IDX_W'(lo);
                    r.match_count = CNT_W'(hi - lo);
                end
                else
                    r.status = ST_EMPTY;
            end
        end
        return r;
    endfunction

    function automatic cmd_item_t op(cmd_t c, int s, logic [TIME_W-1:0] st,
                                     logic [VAL_W-1:0] v, bit w,
                                     logic [TIME_W-1:0] rs, logic [TIME_W-1:0] re);
        cmd_item_t it;
        it.command      = c;
        it.series       = SER_W'(s);
        it.stamp        = st;
        it.sample_value = v;
        it.which_end    = w;
        it.range_start  = rs;
        it.range_end    = re;
        return it;
    endfunction

    function automatic rsp_item_t res(status_t st, int cs, logic [TIME_W-1:0] t,
                                      int fi, int mc);
        rsp_item_t r;
        r.status         = st;
        r.created_series = SER_W'(cs);
        r.time_out       = t;
        r.first_index    = IDX_W'(fi);
        r.match_count    = CNT_W'(mc);
        return r;
    endfunction

    task automatic plan(cmd_item_t it, bit typed, rsp_item_t want);
        plan_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        plan_rows.push_back(row);
    endtask

    // Mostly ascending stamps per series, with range bounds taken from stored stamps.
    function automatic cmd_item_t roll_item(bit flooding);
        cmd_item_t         c;
        int                pick;
        int                s;
        int                n;
        logic [TIME_W-1:0] lo_t;
        logic [TIME_W-1:0] hi_t;
        c.command      = CMD_CREATE;
        c.series       = SER_W'($urandom_range(0, MAX_SERIES - 1));
        c.stamp        = {$urandom, $urandom};
        c.sample_value = $urandom;
        c.which_end    = 1'($urandom_range(0, 1));
        c.range_start  = {$urandom, $urandom};
        c.range_end    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (flooding)
        begin
            c.series = SER_W'(FLOOD_SERIES);
            if (pick < 90)
                c.command = CMD_APPEND;
            else if (pick < 95)
                c.command = CMD_RANGE;
            else
                c.command = CMD_ENDS;
        end
        else
        begin
            if (pick < 8)
                c.command = CMD_CREATE;
            else if (pick < 50)
                c.command = CMD_APPEND;
            else if (pick < 65)
                c.command = CMD_ENDS;
            else
                c.command = CMD_RANGE;
            if (ser_made > 0 && $urandom_range(0, 99) < 85)
                c.series = SER_W'($urandom_range(0, ser_made - 1));
        end
        s = int'(c.series);
        n = ser_fill[s];
        if (n > 0 && $urandom_range(0, 99) < 85)
            c.stamp = ser_times[s][n - 1] + TIME_W'($urandom_range(0, 1000));
        else if (n == 0 && $urandom_range(0, 1) == 1)
            c.stamp = c.stamp >> $urandom_range(0, 63);
        if (n > 0 && $urandom_range(0, 99) < 80)
        begin
            lo_t = ser_times[s][$urandom_range(0, n - 1)];
            hi_t = ser_times[s][$urandom_range(0, n - 1)];
            if (lo_t > hi_t && $urandom_range(0, 3) != 0)
                {lo_t, hi_t} = {hi_t, lo_t};
            c.range_start = lo_t + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
            c.range_end   = hi_t + TIME_W'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0)
                c.range_start = '0;
            if ($urandom_range(0, 9) == 0)
                c.range_end = TOP_STAMP;
        end
        return c;
    endfunction

    task automatic send_item(cmd_item_t it, bit typed, rsp_item_t want);
        rsp_item_t due;
        if (feed_pct > 0 && $urandom_range(0, 99) < feed_pct)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
        due = series_reply(it);
        replies_due.push_back(typed ? want : due);
    endtask

    initial
    begin : sink_stall
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
                stall--;
            else if (sink_pct > 0 && $urandom_range(0, 99) < sink_pct)
                stall = $urandom_range(1, 8);
            rsp_ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin : check_rsp
        rsp_item_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("response transfer with none outstanding");
                failed = 1'b1;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp.status);
                    failed = 1'b1;
                end
                if (rsp.created_series !== want.created_series)
                begin
                    $error("created_series: expected %0d, actual %0d",
                           want.created_series, rsp.created_series);
                    failed = 1'b1;
                end
                if (rsp.time_out !== want.time_out)
                begin
                    $error("time_out: expected %h, actual %h", want.time_out, rsp.time_out);
                    failed = 1'b1;
                end
                if (rsp.first_index !== want.first_index)
                begin
                    $error("first_index: expected %0d, actual %0d",
                           want.first_index, rsp.first_index);
                    failed = 1'b1;
                end
                if (rsp.match_count !== want.match_count)
                begin
                    $error("match_count: expected %0d, actual %0d",
                           want.match_count, rsp.match_count);
                    failed = 1'b1;
                end
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= LIMIT);
        $display("timeseries_append_range_store_top regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        cmd_item_t it;
        int        k;

        // unknown series before any create
        plan(op(CMD_ENDS, 0, '0, '0, 1'b0, '0, '0), 1'b1, res(ST_REJECT, 0, '0, 0, 0));
        plan(op(CMD_APPEND, 15, TOP_STAMP, '1, 1'b1, TOP_STAMP, TOP_STAMP), 1'b1,
             res(ST_REJECT, 0, '0, 0, 0));
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, '0, TOP_STAMP), 1'b1, res(ST_REJECT, 0, '0, 0, 0));
        plan(op(CMD_CREATE, 9, TOP_STAMP, '1, 1'b1, TOP_STAMP, TOP_STAMP), 1'b1,
             res(ST_OK, 0, '0, 0, 0));
        // empty series
        plan(op(CMD_ENDS, 0, '0, '0, 1'b1, '0, '0), 1'b1, res(ST_EMPTY, 0, '0, 0, 0));
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, '0, TOP_STAMP), 1'b1, res(ST_EMPTY, 0, '0, 0, 0));
        // stamps out of order, extremes included
        plan(op(CMD_APPEND, 0, '0, '0, 1'b0, '0, '0), 1'b1, res(ST_OK, 0, '0, 0, 0));
        plan(op(CMD_APPEND, 0, 64'd100, '1, 1'b0, '0, '0), 1'b1, res(ST_OK, 0, '0, 0, 0));
        plan(op(CMD_APPEND, 0, 64'd200, 32'h5a5a_a5a5, 1'b1, '0, '0), 1'b0, '0);
        plan(op(CMD_APPEND, 0, 64'd50, 32'h1234_5678, 1'b0, '0, '0), 1'b0, '0);
        plan(op(CMD_APPEND, 0, TOP_STAMP, '1, 1'b1, TOP_STAMP, TOP_STAMP), 1'b1,
             res(ST_OK, 0, '0, 0, 0));
        plan(op(CMD_ENDS, 0, '0, '0, 1'b0, '0, '0), 1'b1, res(ST_OK, 0, '0, 0, 0));
        plan(op(CMD_ENDS, 0, '0, '0, 1'b1, '0, '0), 1'b1, res(ST_OK, 0, TOP_STAMP, 0, 0));
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, 64'd100, 64'd200), 1'b0, '0);
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, '0, TOP_STAMP), 1'b0, '0);
        // empty range, both bounds inverted and both at the top
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, 64'd150, '0), 1'b0, '0);
        plan(op(CMD_RANGE, 0, '0, '0, 1'b0, TOP_STAMP, TOP_STAMP), 1'b0, '0);
        plan(op(CMD_CREATE, 0, '0, '0, 1'b0, '0, '0), 1'b1, res(ST_OK, 1, '0, 0, 0));
        plan(op(CMD_APPEND, 1, 64'd10, 32'h0000_0001, 1'b0, '0, '0), 1'b0, '0);
        plan(op(CMD_ENDS, 1, '0, '0, 1'b1, '0, '0), 1'b0, '0);
        // start past the last sample, then no end match
        plan(op(CMD_RANGE, 1, '0, '0, 1'b0, 64'd11, TOP_STAMP), 1'b1,
             res(ST_EMPTY, 0, '0, 0, 0));
        plan(op(CMD_RANGE, 1, '0, '0, 1'b0, 64'd5, 64'd20), 1'b0, '0);
        plan(op(CMD_RANGE, 1, '0, '0, 1'b0, '0, 64'd5), 1'b0, '0);
        plan(op(CMD_APPEND, 2, 64'd7, 32'h8000_0000, 1'b0, '0, '0), 1'b1,
             res(ST_REJECT, 0, '0, 0, 0));
        plan(op(CMD_ENDS, 15, '0, '0, 1'b1, '0, '0), 1'b1, res(ST_REJECT, 0, '0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        feed_pct = 25;
        sink_pct = 25;
        foreach (plan_rows[r])
            send_item(plan_rows[r].item, plan_rows[r].typed, plan_rows[r].want);

        for (k = 0; k < N_RANDOM; k++)
        begin
            if (k % 64 == 0)
            begin
                feed_pct = 25 * $urandom_range(0, 2);
                sink_pct = 25 * $urandom_range(0, 2);
            end
            if (k >= N_RANDOM - TAIL)
            begin
                feed_pct = 0;
                sink_pct = 0;
            end
            it = roll_item(k >= FLOOD_AT && k < FLOOD_AT + FLOOD_LEN);
            send_item(it, 1'b0, '0);
        end

        cmd_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (!failed)
            $display("timeseries_append_range_store_top regression: pass");
        else
            $display("timeseries_append_range_store_top regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/tars_pkg.sv
hw/rtl/tars_ram.sv
hw/rtl/tars_dir.sv
hw/rtl/tars_ctrl.sv
hw/rtl/timeseries_append_range_store_top.sv
hw/rtl/tars_checker.sv
bench/tb_timeseries_append_range_store_top.sv
